// ===== rtl/ordered_insert_erase_array_core_assert.svh =====
// Assertion macros used by the array core RTL.
`ifndef ORDERED_INSERT_ERASE_ARRAY_CORE_ASSERT_SVH
`define ORDERED_INSERT_ERASE_ARRAY_CORE_ASSERT_SVH

// Same-cycle implication.
`define OIEA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oiea assertion failed");

// Next-cycle implication.
`define OIEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oiea assertion failed");

`endif

// ===== rtl/oiea_pkg.sv =====
package oiea_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 2;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_op;

endpackage

// ===== rtl/ordered_insert_erase_array_core.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | i_valid / o_ready    | i_mode, i_slot_index, i_elem_value
// output   | o_valid / i_ready    | o_read_value, o_placed_at, o_status, o_count,
//          |                      | o_is_empty
//
// One beat per cycle while o_ready is high: cells shift or load in the cycle the beat is taken.
// Result appears in the output register in the cycle after acceptance.
// Input is taken whenever the output register is empty or being drained.
// Synchronous active-low reset clears the count and output valid; cell contents
// are undefined until written.
module ordered_insert_erase_array_core #(
    parameter int CAPACITY = oiea_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [oiea_pkg::MODE_W-1:0]    i_mode,
    input  logic [CW-1:0]                  i_slot_index,
    input  logic signed [oiea_pkg::DATA_W-1:0] i_elem_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [oiea_pkg::DATA_W-1:0] o_read_value,
    output logic [CW-1:0]                  o_placed_at,
    output logic [oiea_pkg::STATUS_W-1:0]  o_status,
    output logic [CW-1:0]                  o_count,
    output logic                           o_is_empty
);
    import oiea_pkg::*;
    `include "ordered_insert_erase_array_core_assert.svh"

    localparam logic [CW-1:0] L_CAP = CW'(CAPACITY);

    logic                 w_acc;
    t_cell_op             w_op;
    logic [CW-1:0]        w_pos;
    logic [DATA_W-1:0]    w_data [CAPACITY];
    logic [DATA_W-1:0]    w_rd_any;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_read_value;
    logic [DATA_W-1:0]    n_read_value;
    logic [CW-1:0]        r_placed_at;
    logic [CW-1:0]        n_placed_at;
    logic [STATUS_W-1:0]  r_status;
    logic [STATUS_W-1:0]  n_status;
    logic                 w_ins;
    logic                 w_del;

    assign o_ready = !r_out_valid || i_ready;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        w_rd_any = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_any = w_rd_any | (w_data[k] & {DATA_W{i_slot_index == CW'(k)}});
        end
    end

    always_comb begin
        n_count      = r_count;
        n_status     = ST_OK;
        n_read_value = '0;
        n_placed_at  = '0;
        w_ins        = 1'b0;
        w_del        = 1'b0;
        w_pos        = i_slot_index;
        case (i_mode)
            MODE_APPEND: begin
                if (r_count >= L_CAP) begin
                    n_status = ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    w_pos   = r_count;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            MODE_INSERT: begin
                if (i_slot_index > r_count) begin
                    n_status = ST_RANGE;
                end else if (r_count >= L_CAP) begin
                    n_status = ST_FULL;
                end else begin
                    w_ins       = 1'b1;
                    n_placed_at = i_slot_index;
                    n_count     = r_count + CW'(1);
                end
            end
            MODE_ERASE: begin
                if (i_slot_index >= r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    w_del   = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            MODE_READ: begin
                if (i_slot_index >= r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_read_value = w_rd_any;
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    assign w_op.ins = w_acc && w_ins;
    assign w_op.del = w_acc && w_del;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        oiea_cell #(
            .IDX_W (CW),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_pos   (w_pos),
            .i_value (i_elem_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_read_value <= n_read_value;
            r_placed_at  <= n_placed_at;
            r_status     <= n_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_placed_at  = r_placed_at;
    assign o_status     = r_status;
    assign o_count      = r_count;
    assign o_is_empty   = (r_count == '0);

    `OIEA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= L_CAP)
    `OIEA_ASSERT_NEXT(a_acc_gives_valid, i_clk, i_rst_n, w_acc, r_out_valid)
    `OIEA_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !w_acc, $stable(r_count))
    `OIEA_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, w_op.ins,
        r_count == $past(r_count) + CW'(1))
    `OIEA_ASSERT_NEXT(a_del_shrinks, i_clk, i_rst_n, w_op.del,
        r_count == $past(r_count) - CW'(1))

endmodule

// ===== rtl/oiea_cell.sv =====
module oiea_cell #(
    parameter int IDX_W = 7,
    parameter int IDX   = 0
) (
    input  logic                       i_clk,
    input  oiea_pkg::t_cell_op         i_op,
    input  logic [IDX_W-1:0]           i_pos,
    input  logic [oiea_pkg::DATA_W-1:0] i_value,
    input  logic [oiea_pkg::DATA_W-1:0] i_left,
    input  logic [oiea_pkg::DATA_W-1:0] i_right,
    output logic [oiea_pkg::DATA_W-1:0] o_data
);
    import oiea_pkg::*;

    localparam logic [IDX_W-1:0] L_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (L_IDX > i_pos) begin
                n_data = i_left;
            end else if (L_IDX == i_pos) begin
                n_data = i_value;
            end
        end else if (i_op.del) begin
            if (L_IDX >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
